// File: rtl/smf_pkg.sv
package smf_pkg;

    localparam int NowW    = 63;
    localparam int StarveW = 32;
    localparam int CntW    = 32;
    localparam int CfgW    = 32;
    localparam int TrialW  = 64;
    localparam int CfgIdxW = 2;

    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_MUTED = 2'd1;
    localparam logic [1:0] EV_RETRY = 2'd2;

    localparam logic [CfgIdxW-1:0] CFG_MUTE_AFTER = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_MUTE_RETRY = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_MUTE_TRIAL = 2'd2;

    localparam logic [CfgW-1:0] MUTE_AFTER_RST = 32'd5000000;
    localparam logic [CfgW-1:0] MUTE_RETRY_RST = 32'd30000000;
    localparam logic [CfgW-1:0] MUTE_TRIAL_RST = 32'd10000000;

    typedef struct packed {
        logic [CfgW-1:0] bad_limit_us;
        logic [CfgW-1:0] retry_wait_us;
        logic [CfgW-1:0] trial_len_us;
    } t_smf_cfg;

    typedef struct packed {
        logic [StarveW-1:0] last_starve;
        logic [NowW-1:0]    bad_start_time;
        logic [NowW-1:0]    muted_time;
        logic [TrialW-1:0]  trial_end_time;
        logic [CntW-1:0]    mute_count;
        logic [CntW-1:0]    retry_count;
    } t_smf_state;

    typedef struct packed {
        logic            stay_off;
        logic [1:0]      event_code;
        logic [CntW-1:0] mute_total;
        logic [CntW-1:0] retry_total;
    } t_smf_result;

endpackage

// File: rtl/smf_core.sv
module smf_core (
    input  smf_pkg::t_smf_cfg              i_cfg,
    input  smf_pkg::t_smf_state            i_state,
    input  logic [smf_pkg::NowW-1:0]       i_now_us,
    input  logic [smf_pkg::StarveW-1:0]    i_starve_total,
    output smf_pkg::t_smf_state            o_state,
    output smf_pkg::t_smf_result           o_result
);

    logic                       bad;
    logic [smf_pkg::NowW-1:0]   muted_diff;
    logic [smf_pkg::NowW-1:0]   bad_diff;
    logic                       muted_hold;
    logic                       bad_short;
    logic                       in_trial;

    assign bad        = (i_starve_total != i_state.last_starve);
    assign muted_diff = i_now_us - i_state.muted_time;
    assign bad_diff   = i_now_us - i_state.bad_start_time;
    // A timestamp behind the reference point always counts as still within the limit.
    assign muted_hold = (i_now_us < i_state.muted_time) ||
                        (muted_diff < {{(smf_pkg::NowW-smf_pkg::CfgW){1'b0}},
                                       i_cfg.retry_wait_us});
    assign bad_short  = (i_now_us < i_state.bad_start_time) ||
                        (bad_diff < {{(smf_pkg::NowW-smf_pkg::CfgW){1'b0}},
                                     i_cfg.bad_limit_us});
    assign in_trial   = ({1'b0, i_now_us} < i_state.trial_end_time);

    always_comb begin
        o_state             = i_state;
        o_state.last_starve = i_starve_total;
        o_result.stay_off   = 1'b0;
        o_result.event_code = smf_pkg::EV_NONE;
        priority if (i_state.muted_time != '0) begin
            if (muted_hold) begin
                o_result.stay_off = 1'b1;
            end else begin
                o_state.muted_time     = '0;
                o_state.bad_start_time = '0;
                o_state.trial_end_time = {1'b0, i_now_us} +
                    {{(smf_pkg::TrialW-smf_pkg::CfgW){1'b0}}, i_cfg.trial_len_us};
                o_state.retry_count    = i_state.retry_count + 1'b1;
                o_result.event_code    = smf_pkg::EV_RETRY;
            end
        end else if (!bad || in_trial) begin
            o_state.bad_start_time = '0;
        end else if (i_state.bad_start_time == '0) begin
            o_state.bad_start_time = i_now_us;
        end else if (!bad_short) begin
            o_state.muted_time     = i_now_us;
            o_state.bad_start_time = '0;
            o_state.mute_count     = i_state.mute_count + 1'b1;
            o_result.stay_off      = 1'b1;
            o_result.event_code    = smf_pkg::EV_MUTED;
        end else begin
            // The bad stretch goes on without reaching the limit.
            o_state.bad_start_time = i_state.bad_start_time;
        end
        o_result.mute_total  = o_state.mute_count;
        o_result.retry_total = o_state.retry_count;
    end

endmodule

// File: rtl/starvation_self_mute_fsm.sv
// Starvation self-mute controller. Each input beat is one tick carrying the
// current microsecond time and the cumulative starvation count; every tick
// yields exactly one result beat with the stay-off flag, an event code and the
// mute and retry totals. A tick passes an input register and then a result
// register, moving on once the result register is free or being read, and one
// tick can be accepted every cycle while the result stream is not held back;
// the state update between the two registers is combinational. Configuration writes
// take effect on the next clock edge and should be made while no tick is in flight.
module starvation_self_mute_fsm (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [95:0] i_s_axis_tdata,   // now_us[62:0], starve_total[94:63], zero
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [71:0] o_m_axis_tdata,   // stay_off, event_code, mute_total,
                                          // retry_total, zero fill
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata
);

    smf_pkg::t_smf_cfg    r_cfg;
    smf_pkg::t_smf_state  r_state;
    smf_pkg::t_smf_state  n_state;
    smf_pkg::t_smf_result n_result;
    smf_pkg::t_smf_result r_result;

    logic                         r_in_valid;
    logic [smf_pkg::NowW-1:0]     r_now;
    logic [smf_pkg::StarveW-1:0]  r_starve;
    logic                         r_out_valid;
    logic                         out_free;
    logic                         advance;

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign advance         = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || out_free;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_result.retry_total, r_result.mute_total,
                              r_result.event_code, r_result.stay_off};

    smf_core u_core (
        .i_cfg          (r_cfg),
        .i_state        (r_state),
        .i_now_us       (r_now),
        .i_starve_total (r_starve),
        .o_state        (n_state),
        .o_result       (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bad_limit_us  <= smf_pkg::MUTE_AFTER_RST;
            r_cfg.retry_wait_us <= smf_pkg::MUTE_RETRY_RST;
            r_cfg.trial_len_us  <= smf_pkg::MUTE_TRIAL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                smf_pkg::CFG_MUTE_AFTER: r_cfg.bad_limit_us  <= i_cfg_wdata;
                smf_pkg::CFG_MUTE_RETRY: r_cfg.retry_wait_us <= i_cfg_wdata;
                smf_pkg::CFG_MUTE_TRIAL: r_cfg.trial_len_us  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_now    <= i_s_axis_tdata[62:0];
            r_starve <= i_s_axis_tdata[94:63];
        end
        if (advance) begin
            r_result <= n_result;
        end
    end

    a_mute_clears_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.muted_time != '0) |-> (r_state.bad_start_time == '0))
        else $error("bad stretch recorded while muted");

    a_retry_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && n_result.event_code == smf_pkg::EV_RETRY) |=>
        (r_state.retry_count == $past(r_state.retry_count) + 1'b1))
        else $error("retry event without retry count step");

    a_count_only_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> ($stable(r_state.mute_count) && $stable(r_state.retry_count)))
        else $error("event counter changed without a tick");

endmodule

// File: dv/starvation_self_mute_fsm_test.sv
`timescale 1ns / 1ps

module starvation_self_mute_fsm_test;

    localparam logic [63:0]              TIME_CEIL   = 64'h7FFF_F000_0000_0000;
    localparam logic [63:0]              TIME_DROP   = 64'h0000_1000_0000_0000;
    localparam logic [63:0]              LATE_START  = 64'h7FFF_FF00_0000_0000;
    localparam logic [63:0]              LATE_STEP   = 64'h0000_0002_0000_0000;
    localparam logic [smf_pkg::NowW-1:0] NOW_MAX     = '1;
    localparam logic [smf_pkg::CfgW-1:0] CFG_MAX     = '1;
    localparam int                       PHASE_TICKS = 150;
    localparam int                       HOLD_CYCLES = 300;
    localparam int                       DRAIN_CYCLES = 4;

    class mute_fsm_scoreboard;
        logic [smf_pkg::CfgW-1:0]    after_us;
        logic [smf_pkg::CfgW-1:0]    retry_us;
        logic [smf_pkg::CfgW-1:0]    trial_us;
        logic [smf_pkg::StarveW-1:0] seen_starve;
        logic [63:0]                 bad_since;
        logic [63:0]                 muted_at;
        logic [63:0]                 trial_until;
        logic [smf_pkg::CntW-1:0]    mutes;
        logic [smf_pkg::CntW-1:0]    retries;
        smf_pkg::t_smf_result        expected_results[$];
        int                          errors;
        int                          ticks;
        int                          mute_events;
        int                          retry_events;

        function new();
            after_us     = smf_pkg::MUTE_AFTER_RST;
            retry_us     = smf_pkg::MUTE_RETRY_RST;
            trial_us     = smf_pkg::MUTE_TRIAL_RST;
            seen_starve  = '0;
            bad_since    = '0;
            muted_at     = '0;
            trial_until  = '0;
            mutes        = '0;
            retries      = '0;
            errors       = 0;
            ticks        = 0;
            mute_events  = 0;
            retry_events = 0;
        endfunction

        function void set_reg(logic [smf_pkg::CfgIdxW-1:0] idx,
                              logic [smf_pkg::CfgW-1:0] value);
            case (idx)
                smf_pkg::CFG_MUTE_AFTER: after_us = value;
                smf_pkg::CFG_MUTE_RETRY: retry_us = value;
                smf_pkg::CFG_MUTE_TRIAL: trial_us = value;
                default: ;
            endcase
        endfunction

        // A timestamp behind the reference point always counts as still within the limit.
        function bit still_within(logic [63:0] now_us, logic [63:0] since,
                                  logic [smf_pkg::CfgW-1:0] lim);
            return (now_us < since) || ((now_us - since) < {32'd0, lim});
        endfunction

        function void note_tick(logic [smf_pkg::NowW-1:0] now_in,
                                logic [smf_pkg::StarveW-1:0] starve);
            logic [63:0]          now_us;
            logic                 bad;
            smf_pkg::t_smf_result res;
            now_us = {1'b0, now_in};
            bad = (starve != seen_starve);
            seen_starve = starve;
            res.stay_off = 1'b0;
            res.event_code = smf_pkg::EV_NONE;
            if (muted_at != 0) begin
                if (still_within(now_us, muted_at, retry_us)) begin
                    res.stay_off = 1'b1;
                end else begin
                    muted_at = '0;
                    bad_since = '0;
                    trial_until = now_us + {32'd0, trial_us};
                    retries++;
                    retry_events++;
                    res.event_code = smf_pkg::EV_RETRY;
                end
            end else if (!bad || now_us < trial_until) begin
                bad_since = '0;
            end else if (bad_since == 0) begin
                bad_since = now_us;
            end else if (!still_within(now_us, bad_since, after_us)) begin
                muted_at = now_us;
                bad_since = '0;
                mutes++;
                mute_events++;
                res.stay_off = 1'b1;
                res.event_code = smf_pkg::EV_MUTED;
            end
            res.mute_total = mutes;
            res.retry_total = retries;
            expected_results.push_back(res);
            ticks++;
        endfunction

        function void check_field(string what, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
            end
        endfunction

        function void check_result(logic [71:0] data);
            smf_pkg::t_smf_result want;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: result beat with no tick outstanding, expected none, got %h",
                         $time, data);
                return;
            end
            want = expected_results.pop_front();
            check_field("stay_off", 32'(want.stay_off), 32'(data[0]));
            check_field("event_code", 32'(want.event_code), 32'(data[2:1]));
            check_field("mute_total", want.mute_total, data[34:3]);
            check_field("retry_total", want.retry_total, data[66:35]);
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [95:0]                   s_tdata = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [71:0]                   m_tdata;
    logic                          cfg_we = 1'b0;
    logic [smf_pkg::CfgIdxW-1:0]   cfg_idx = smf_pkg::CFG_MUTE_AFTER;
    logic [smf_pkg::CfgW-1:0]      cfg_wdata = '0;

    mute_fsm_scoreboard            sb = new();
    int unsigned                   send_idle_pct = 36;
    int unsigned                   recv_idle_pct = 82;
    int                            ticks_sent = 0;
    int                            settings_used = 0;
    bit                            hold_off_req = 1'b0;
    logic [63:0]                   clock_us = '0;
    logic [smf_pkg::StarveW-1:0]   starve_cur = '0;

    starvation_self_mute_fsm i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_wdata)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("%0t: run timed out with %0d results outstanding", $time, sb.pending());
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        forever begin
            @(posedge clk);
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata);
            end
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic send_tick(input logic [smf_pkg::NowW-1:0] now_us,
                             input logic [smf_pkg::StarveW-1:0] starve);
        if (ticks_sent < 420) begin
            send_idle_pct = 36;
            recv_idle_pct = 82;
        end else if (ticks_sent < 840) begin
            send_idle_pct = 82;
            recv_idle_pct = 36;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        if (ticks_sent == 840) begin
            hold_off_req = 1'b1;
        end
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, starve, now_us};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_tick(now_us, starve);
        ticks_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input logic [smf_pkg::CfgW-1:0] after_v,
                                input logic [smf_pkg::CfgW-1:0] retry_v,
                                input logic [smf_pkg::CfgW-1:0] trial_v);
        logic [smf_pkg::CfgIdxW-1:0] idxs[3];
        logic [smf_pkg::CfgW-1:0]    vals[3];
        idxs = '{smf_pkg::CFG_MUTE_AFTER, smf_pkg::CFG_MUTE_RETRY, smf_pkg::CFG_MUTE_TRIAL};
        vals = '{after_v, retry_v, trial_v};
        for (int i = 0; i < 3; i++) begin
            cfg_we <= 1'b1;
            cfg_idx <= idxs[i];
            cfg_wdata <= vals[i];
            @(posedge clk);
            sb.set_reg(idxs[i], vals[i]);
        end
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Mostly forward-moving runs of ticks with long starvation stretches, mixed with
    // timestamps that jump back, restart at zero, or land at random.
    task automatic run_phase(input logic [smf_pkg::CfgW-1:0] after_v,
                             input logic [smf_pkg::CfgW-1:0] retry_v,
                             input logic [smf_pkg::CfgW-1:0] trial_v,
                             input int unsigned step_max);
        int          sent;
        int          run_len;
        int unsigned bad_pct;
        int unsigned pick;
        logic [63:0] back;
        logic [63:0] now_us;
        sent = 0;
        drain();
        write_config(after_v, retry_v, trial_v);
        while (sent < PHASE_TICKS) begin
            run_len = $urandom_range(15, 80);
            bad_pct = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 100)
                                                  : $urandom_range(85, 100);
            case ($urandom_range(0, 9))
                0: clock_us = '0;
                1: begin
                    clock_us = {$urandom, $urandom} >> 1;
                    if (clock_us > TIME_CEIL) begin
                        clock_us = clock_us - TIME_DROP;
                    end
                end
                default: ;
            endcase
            for (int k = 0; k < run_len && sent < PHASE_TICKS; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 4) begin
                    now_us = (clock_us == 0) ? 64'd0 : ({$urandom, $urandom} % (clock_us + 1));
                    starve_cur = $urandom;
                end else begin
                    if (pick < 9) begin
                        back = 64'($urandom_range(0, step_max));
                        now_us = (clock_us > back) ? clock_us - back : 64'd0;
                    end else begin
                        clock_us = clock_us + 64'($urandom_range(0, step_max));
                        now_us = clock_us;
                    end
                    if ($urandom_range(0, 99) < bad_pct) begin
                        starve_cur = starve_cur + (($urandom_range(0, 3) == 0) ? $urandom : 32'd1);
                    end
                end
                send_tick(now_us[smf_pkg::NowW-1:0], starve_cur);
                sent++;
            end
        end
    endtask

    initial begin
        logic [63:0]                 d_now[19];
        logic [smf_pkg::StarveW-1:0] d_starve[19];
        d_now = '{64'd0, 64'd1000, 64'd2000, 64'd3000, 64'd2000, 64'd2_500_000,
                  64'd5_003_000, 64'd10_000_000, 64'd4_000_000, 64'd35_002_999,
                  64'd35_003_000, 64'd36_000_000, 64'd45_002_999, 64'd45_003_000,
                  64'd50_002_999, 64'd50_003_000, 64'd50_004_000, 64'd60_000_000,
                  64'd60_000_001};
        d_starve = '{32'd5, 32'd6, 32'd6, 32'd7, 32'd8, 32'd9, 32'd10, 32'd10, 32'd11,
                     32'd12, 32'd13, 32'd14, 32'd15, 32'd16, 32'd17, 32'd17, 32'd18,
                     32'hFFFF_FFFF, 32'd0};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < 19; i++) begin
            send_tick(d_now[i][smf_pkg::NowW-1:0], d_starve[i]);
        end
        clock_us = d_now[18];
        starve_cur = d_starve[18];

        run_phase('0, '0, '0, 500);
        run_phase($urandom_range(0, 3000), $urandom_range(0, 6000), $urandom_range(0, 4000), 600);
        run_phase(CFG_MAX, CFG_MAX, CFG_MAX, 32'hFFFF_FFFF);
        run_phase($urandom_range(0, 3000), $urandom_range(0, 6000), $urandom_range(0, 4000), 600);
        run_phase('0, CFG_MAX, '0, 1000);
        run_phase($urandom, $urandom, $urandom, $urandom);
        run_phase(smf_pkg::MUTE_AFTER_RST, smf_pkg::MUTE_RETRY_RST, smf_pkg::MUTE_TRIAL_RST,
                  400_000);
        run_phase($urandom_range(0, 3000), $urandom_range(0, 6000), $urandom_range(0, 4000), 600);

        // Get muted near the top of the time range, then retry at the largest timestamp so
        // that the end of the trial window needs the 64th bit.
        drain();
        write_config('0, '0, CFG_MAX);
        clock_us = LATE_START;
        for (int k = 0; k < 6 && sb.muted_at == 0; k++) begin
            clock_us = clock_us + LATE_STEP;
            starve_cur++;
            send_tick(clock_us[smf_pkg::NowW-1:0], starve_cur);
        end
        starve_cur++;
        send_tick(NOW_MAX, starve_cur);
        starve_cur++;
        send_tick(NOW_MAX, starve_cur);

        drain();
        $display("Ran %0d ticks under %0d register settings plus the reset values.",
                 sb.ticks, settings_used);
        $display("Predicted %0d mutes and %0d retries, with %0d mismatches.",
                 sb.mute_events, sb.retry_events, sb.errors);
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/smf_pkg.sv
rtl/smf_core.sv
rtl/starvation_self_mute_fsm.sv
dv/starvation_self_mute_fsm_test.sv
